// ----- design/note_inventory_greedy_dispenser_macros.svh -----
// Assertion macros shared by the note inventory dispenser RTL.
`ifndef NOTE_INVENTORY_GREEDY_DISPENSER_MACROS_SVH
`define NOTE_INVENTORY_GREEDY_DISPENSER_MACROS_SVH

`ifndef SYNTH
`define NIGD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define NIGD_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define NIGD_ASSERT(lbl, clk, rstn, prop)
`define NIGD_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ----- design/nigd_pkg.sv -----
// Types, constants and division tables for the note inventory dispenser.
package nigd_pkg;

  localparam int COUNT_WIDTH  = 16;
  localparam int AMOUNT_WIDTH = 20;
  localparam int TOTAL_W      = 24;
  localparam int FACE_W       = 7;
  localparam int NUM_VALUES   = 6;
  localparam int IDX_W        = $clog2(NUM_VALUES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VALUES - 1);

  // Reciprocal constants: for an AMOUNT_WIDTH-bit x and divisor d with
  // l = ceil(log2 d), floor(x / d) == (x * ceil(2^(AW+l) / d)) >> (AW+l).
  localparam int MAGIC_W = AMOUNT_WIDTH + 1;
  localparam int PROD_W  = AMOUNT_WIDTH + MAGIC_W;
  localparam int SHIFT_W = $clog2(AMOUNT_WIDTH + 8);
  localparam int QD_W    = AMOUNT_WIDTH + FACE_W;
  localparam int CMP_W   = (AMOUNT_WIDTH > COUNT_WIDTH) ? AMOUNT_WIDTH : COUNT_WIDTH;
  localparam int REP_W   = COUNT_WIDTH + FACE_W;

  localparam logic [FACE_W-1:0] FACE [NUM_VALUES] = '{
    FACE_W'(100), FACE_W'(50), FACE_W'(20), FACE_W'(10), FACE_W'(5), FACE_W'(1)
  };

  localparam logic [COUNT_WIDTH-1:0] STOCK_RESET [NUM_VALUES] = '{
    COUNT_WIDTH'(1), COUNT_WIDTH'(75), COUNT_WIDTH'(100),
    COUNT_WIDTH'(100), COUNT_WIDTH'(100), COUNT_WIDTH'(100)
  };

  localparam logic [MAGIC_W-1:0] DIV_MAGIC [NUM_VALUES] = '{
    MAGIC_W'(((64'd1 << (AMOUNT_WIDTH + 7)) + 64'd99) / 64'd100),
    MAGIC_W'(((64'd1 << (AMOUNT_WIDTH + 6)) + 64'd49) / 64'd50),
    MAGIC_W'(((64'd1 << (AMOUNT_WIDTH + 5)) + 64'd19) / 64'd20),
    MAGIC_W'(((64'd1 << (AMOUNT_WIDTH + 4)) + 64'd9) / 64'd10),
    MAGIC_W'(((64'd1 << (AMOUNT_WIDTH + 3)) + 64'd4) / 64'd5),
    MAGIC_W'(64'd1 << AMOUNT_WIDTH)
  };

  localparam logic [SHIFT_W-1:0] DIV_SHIFT [NUM_VALUES] = '{
    SHIFT_W'(AMOUNT_WIDTH + 7), SHIFT_W'(AMOUNT_WIDTH + 6), SHIFT_W'(AMOUNT_WIDTH + 5),
    SHIFT_W'(AMOUNT_WIDTH + 4), SHIFT_W'(AMOUNT_WIDTH + 3), SHIFT_W'(AMOUNT_WIDTH)
  };

  typedef enum logic [1:0] {
    KIND_DEPOSIT  = 2'd0,
    KIND_WITHDRAW = 2'd1,
    KIND_REPORT   = 2'd2,
    KIND_NONE     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]              kind;
    logic [7:0]              note_value;
    logic [COUNT_WIDTH-1:0]  note_count;
    logic [AMOUNT_WIDTH-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [FACE_W-1:0]       paid_value;
    logic [COUNT_WIDTH-1:0]  paid_count;
    logic [AMOUNT_WIDTH-1:0] remaining;
    logic [TOTAL_W-1:0]      total_value;
    logic                    accepted;
    logic                    last;
  } out_item_t;

endpackage

// ----- design/note_inventory_greedy_dispenser.sv -----
// Note stock memory with deposit, greedy withdraw and total report.
// Deposit passes READ, EVAL and FINISH; an unknown deposit value or kind 3 goes straight to
// FINISH; report and withdraw step READ and EVAL over all six values, and withdraw waits in EVAL.
// One transaction at a time; the next input is taken the cycle after the last result is
// registered, and any output stall holds the block longer.
// Reset restores the stock to 1,75,100,100,100,100 at once through per-entry valid flags.
`include "note_inventory_greedy_dispenser_macros.svh"

module note_inventory_greedy_dispenser
  import nigd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  state_e state_q, state_d;
  kind_e  op_q, op_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic [AMOUNT_WIDTH-1:0] amt_q, amt_d;
  logic [COUNT_WIDTH-1:0]  cnt_q, cnt_d;
  logic                    match_q, match_d;
  logic [PROD_W-1:0]       prod_q, prod_d;
  logic                    pend_valid_q, pend_valid_d;
  logic [FACE_W-1:0]       pend_value_q, pend_value_d;
  logic [COUNT_WIDTH-1:0]  pend_count_q, pend_count_d;
  logic [TOTAL_W-1:0]      tot_q, tot_d;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_q;

  // Stock memory with a registered read.
  logic [COUNT_WIDTH-1:0]  stock_mem [NUM_VALUES];
  logic [NUM_VALUES-1:0]   valid_q;
  logic [COUNT_WIDTH-1:0]  rd_q;
  logic                    rd_vld_q;
  logic                    mem_re, mem_we;
  logic [COUNT_WIDTH-1:0]  mem_wdata;

  logic                    in_accept, can_push, push;
  out_item_t               push_data;
  logic                    dep_hit;
  logic [IDX_W-1:0]        dep_idx;
  logic [COUNT_WIDTH-1:0]  stock;
  logic [AMOUNT_WIDTH-1:0] wd_q;
  logic [QD_W-1:0]         wd_qd;
  logic [AMOUNT_WIDTH-1:0] wd_rem;
  logic                    wd_skip, wd_pay, eval_hold;
  logic [COUNT_WIDTH:0]    dep_sum;
  logic [REP_W-1:0]        rep_prod;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign can_push   = !out_valid_q || !out_stall_i;

  always_comb begin
    dep_hit = 1'b0;
    dep_idx = '0;
    for (int i = 0; i < NUM_VALUES; i++) begin
      if (in_data_i.note_value == {1'b0, FACE[i]}) begin
        dep_hit = 1'b1;
        dep_idx = IDX_W'(i);
      end
    end
  end

  // An entry never written since reset still holds its reset count.
  assign stock = rd_vld_q ? rd_q : STOCK_RESET[idx_q];

  assign wd_q    = AMOUNT_WIDTH'(prod_q >> DIV_SHIFT[idx_q]);
  assign wd_qd   = QD_W'(wd_q) * QD_W'(FACE[idx_q]);
  assign wd_rem  = amt_q - AMOUNT_WIDTH'(wd_qd);
  assign wd_skip = (wd_q != '0) && (CMP_W'(stock) < CMP_W'(wd_q));
  assign wd_pay  = (wd_q != '0) && !wd_skip;
  // A second payout must wait until the earlier one can go to the output register.
  assign eval_hold = (state_q == S_EVAL) && (op_q == KIND_WITHDRAW) &&
                     wd_pay && pend_valid_q && !can_push;

  assign dep_sum  = {1'b0, stock} + {1'b0, cnt_q};
  assign rep_prod = REP_W'(stock) * REP_W'(FACE[idx_q]);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if ((kind_e'(in_data_i.kind) == KIND_NONE) ||
              ((kind_e'(in_data_i.kind) == KIND_DEPOSIT) && !dep_hit)) begin
            state_d = S_FINISH;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        if (op_q == KIND_DEPOSIT) begin
          state_d = S_FINISH;
        end else if (!eval_hold) begin
          state_d = (idx_q == LAST_IDX) ? S_FINISH : S_READ;
        end
      end
      S_FINISH: begin
        if (can_push) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_d         = op_q;
    idx_d        = idx_q;
    amt_d        = amt_q;
    cnt_d        = cnt_q;
    match_d      = match_q;
    prod_d       = prod_q;
    pend_valid_d = pend_valid_q;
    pend_value_d = pend_value_q;
    pend_count_d = pend_count_q;
    tot_d        = tot_q;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    mem_wdata    = '0;
    push         = 1'b0;
    push_data    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          op_d         = kind_e'(in_data_i.kind);
          amt_d        = in_data_i.amount;
          cnt_d        = in_data_i.note_count;
          match_d      = dep_hit;
          idx_d        = (kind_e'(in_data_i.kind) == KIND_DEPOSIT) ? dep_idx : '0;
          tot_d        = '0;
          pend_valid_d = 1'b0;
        end
      end
      S_READ: begin
        mem_re = 1'b1;
        prod_d = PROD_W'(amt_q) * PROD_W'(DIV_MAGIC[idx_q]);
      end
      S_EVAL: begin
        case (op_q)
          KIND_DEPOSIT: begin
            mem_we    = 1'b1;
            mem_wdata = dep_sum[COUNT_WIDTH] ? '1 : dep_sum[COUNT_WIDTH-1:0];
          end
          KIND_WITHDRAW: begin
            if (!eval_hold) begin
              if (!wd_skip) begin
                amt_d = wd_rem;
              end
              if (wd_pay) begin
                mem_we    = 1'b1;
                mem_wdata = stock - COUNT_WIDTH'(wd_q);
                if (pend_valid_q) begin
                  push                 = 1'b1;
                  push_data.paid_value = pend_value_q;
                  push_data.paid_count = pend_count_q;
                  push_data.accepted   = 1'b1;
                end
                pend_valid_d = 1'b1;
                pend_value_d = FACE[idx_q];
                pend_count_d = COUNT_WIDTH'(wd_q);
              end
            end
          end
          default: begin
            tot_d = tot_q + TOTAL_W'(rep_prod);
          end
        endcase
        if ((op_q != KIND_DEPOSIT) && !eval_hold && (idx_q != LAST_IDX)) begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_FINISH: begin
        if (can_push) begin
          push               = 1'b1;
          push_data.last     = 1'b1;
          push_data.accepted = 1'b1;
          case (op_q)
            KIND_DEPOSIT: push_data.accepted = match_q;
            KIND_WITHDRAW: begin
              push_data.remaining = amt_q;
              if (pend_valid_q) begin
                push_data.paid_value = pend_value_q;
                push_data.paid_count = pend_count_q;
              end
            end
            KIND_REPORT: push_data.total_value = tot_q;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = push || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= KIND_NONE;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      valid_q      <= '0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (mem_we) begin
        valid_q[idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    amt_q        <= amt_d;
    cnt_q        <= cnt_d;
    match_q      <= match_d;
    prod_q       <= prod_d;
    pend_value_q <= pend_value_d;
    pend_count_q <= pend_count_d;
    tot_q        <= tot_d;
    if (push) begin
      out_q <= push_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stock_mem[idx_q] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q     <= stock_mem[idx_q];
      rd_vld_q <= valid_q[idx_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `NIGD_ASSERT(a_last_ends_item, clk_i, rst_ni, (push && push_data.last) |=> (state_q == S_IDLE))
  `NIGD_ASSERT(a_accept_leaves_idle, clk_i, rst_ni, in_accept |=> (state_q != S_IDLE))
  `NIGD_ASSERT(a_pend_only_withdraw, clk_i, rst_ni, pend_valid_q |-> (op_q == KIND_WITHDRAW))
  `NIGD_ASSERT_NEVER(a_no_push_on_full, clk_i, rst_ni, push && out_valid_q && out_stall_i)
  `NIGD_ASSERT_NEVER(a_idx_in_range, clk_i, rst_ni, idx_q > LAST_IDX)

endmodule

// ----- verif/note_inventory_greedy_dispenser_tb.sv -----
// Self-checking testbench for the note inventory greedy dispenser.
module note_inventory_greedy_dispenser_tb;
  import nigd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 30;
  localparam logic [FACE_W-1:0] NOTE_FACE [NUM_VALUES] = '{
    FACE_W'(100), FACE_W'(50), FACE_W'(20), FACE_W'(10), FACE_W'(5), FACE_W'(1)
  };

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  // Local copy of the vault contents and the results each transaction owes.
  logic [COUNT_WIDTH-1:0] vault_stock [NUM_VALUES];
  out_item_t due_results [$];
  out_item_t want;

  int fault_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  note_inventory_greedy_dispenser DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Updates the vault copy for one accepted transaction and queues its results.
  task automatic dispense_and_queue(in_item_t it);
    out_item_t               res;
    out_item_t               paid [NUM_VALUES];
    logic [AMOUNT_WIDTH-1:0] left;
    logic [AMOUNT_WIDTH-1:0] quot;
    logic [COUNT_WIDTH:0]    sum;
    longint                  worth;
    int                      n;
    res = '0;
    res.accepted = 1'b1;
    res.last = 1'b1;
    case (kind_e'(it.kind))
      KIND_DEPOSIT: begin
        res.accepted = 1'b0;
        for (int i = 0; i < NUM_VALUES; i++) begin
          if (it.note_value == 8'(NOTE_FACE[i])) begin
            sum = {1'b0, vault_stock[i]} + {1'b0, it.note_count};
            vault_stock[i] = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
            res.accepted = 1'b1;
          end
        end
        due_results.push_back(res);
      end
      KIND_WITHDRAW: begin
        left = it.amount;
        n = 0;
        for (int i = 0; i < NUM_VALUES; i++) begin
          quot = left / AMOUNT_WIDTH'(NOTE_FACE[i]);
          // A value whose stock cannot cover the quotient is skipped entirely.
          if (quot == '0 || AMOUNT_WIDTH'(vault_stock[i]) >= quot) begin
            left = left % AMOUNT_WIDTH'(NOTE_FACE[i]);
            if (quot != '0) begin
              vault_stock[i] = vault_stock[i] - quot[COUNT_WIDTH-1:0];
              paid[n] = '0;
              paid[n].paid_value = NOTE_FACE[i];
              paid[n].paid_count = quot[COUNT_WIDTH-1:0];
              paid[n].accepted = 1'b1;
              n++;
            end
          end
        end
        if (n == 0) begin
          res.remaining = left;
          due_results.push_back(res);
        end else begin
          paid[n-1].remaining = left;
          paid[n-1].last = 1'b1;
          for (int k = 0; k < n; k++) due_results.push_back(paid[k]);
        end
      end
      KIND_REPORT: begin
        worth = 0;
        for (int i = 0; i < NUM_VALUES; i++)
          worth += longint'(NOTE_FACE[i]) * longint'(vault_stock[i]);
        res.total_value = worth[TOTAL_W-1:0];
        due_results.push_back(res);
      end
      default: due_results.push_back(res);
    endcase
  endtask

  task automatic send_item(in_item_t it);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    dispense_and_queue(it);
  endtask

  function automatic in_item_t deposit_item(logic [7:0] value, logic [COUNT_WIDTH-1:0] count);
    in_item_t it;
    it.kind = KIND_DEPOSIT;
    it.note_value = value;
    it.note_count = count;
    it.amount = AMOUNT_WIDTH'($urandom);
    return it;
  endfunction

  function automatic in_item_t withdraw_item(logic [AMOUNT_WIDTH-1:0] amt);
    in_item_t it;
    it.kind = KIND_WITHDRAW;
    it.note_value = 8'($urandom);
    it.note_count = COUNT_WIDTH'($urandom);
    it.amount = amt;
    return it;
  endfunction

  function automatic in_item_t plain_item(kind_e k);
    in_item_t it;
    it.kind = k;
    it.note_value = 8'($urandom);
    it.note_count = COUNT_WIDTH'($urandom);
    it.amount = AMOUNT_WIDTH'($urandom);
    return it;
  endfunction

  task automatic flag_field(string field, logic [31:0] expv, logic [31:0] gotv);
    fault_count++;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, expv, gotv);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected result, expected none actual %p", $time, out_data_o);
      end else begin
        want = due_results.pop_front();
        if (out_data_o.paid_value !== want.paid_value)
          flag_field("paid_value", 32'(want.paid_value), 32'(out_data_o.paid_value));
        if (out_data_o.paid_count !== want.paid_count)
          flag_field("paid_count", 32'(want.paid_count), 32'(out_data_o.paid_count));
        if (out_data_o.remaining !== want.remaining)
          flag_field("remaining", 32'(want.remaining), 32'(out_data_o.remaining));
        if (out_data_o.total_value !== want.total_value)
          flag_field("total_value", 32'(want.total_value), 32'(out_data_o.total_value));
        if (out_data_o.accepted !== want.accepted)
          flag_field("accepted", 32'(want.accepted), 32'(out_data_o.accepted));
        if (out_data_o.last !== want.last)
          flag_field("last", 32'(want.last), 32'(out_data_o.last));
      end
    end
  end

  // Walks from the reset stock: every value paid, an empty hundred, zero and shortfall.
  task automatic test_withdraw_walk();
    send_item(plain_item(KIND_REPORT));
    send_item(withdraw_item(AMOUNT_WIDTH'(186)));
    send_item(withdraw_item(AMOUNT_WIDTH'(100)));
    send_item(withdraw_item(AMOUNT_WIDTH'(0)));
    send_item(withdraw_item('1));
    send_item(withdraw_item(AMOUNT_WIDTH'(3)));
  endtask

  // Known and unknown note values, zero counts and saturation of the hundred.
  task automatic test_deposit_edges();
    send_item(deposit_item(8'd100, '1));
    send_item(deposit_item(8'd100, '1));
    for (int i = 1; i < NUM_VALUES; i++)
      send_item(deposit_item(8'(NOTE_FACE[i]), COUNT_WIDTH'(40 * i)));
    send_item(deposit_item(8'd1, '0));
    send_item(deposit_item(8'd0, COUNT_WIDTH'(7)));
    send_item(deposit_item(8'd255, '1));
    send_item(deposit_item(8'd99, COUNT_WIDTH'(12)));
    send_item(plain_item(KIND_REPORT));
  endtask

  task automatic test_unused_kind();
    send_item(plain_item(KIND_NONE));
    send_item(withdraw_item('1));
    send_item(plain_item(KIND_REPORT));
  endtask

  task automatic test_random_traffic(int count);
    int pick;
    int roll;
    logic [AMOUNT_WIDTH-1:0] amt;
    logic [7:0] value;
    logic [COUNT_WIDTH-1:0] notes;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      roll = $urandom_range(99);
      if (pick < 35) begin
        value = (roll < 80) ? 8'(NOTE_FACE[$urandom_range(NUM_VALUES - 1)])
                            : 8'($urandom_range(255));
        notes = ($urandom_range(99) < 85) ? COUNT_WIDTH'($urandom_range(300))
                                          : COUNT_WIDTH'($urandom_range(65535));
        send_item(deposit_item(value, notes));
      end else if (pick < 80) begin
        if (roll < 50) amt = AMOUNT_WIDTH'($urandom_range(400));
        else if (roll < 80) amt = AMOUNT_WIDTH'($urandom_range(20000));
        else amt = AMOUNT_WIDTH'($urandom);
        send_item(withdraw_item(amt));
      end else if (pick < 95) begin
        send_item(plain_item(KIND_REPORT));
      end else begin
        send_item(plain_item(KIND_NONE));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_VALUES; i++) vault_stock[i] = '0;
    vault_stock[0] = COUNT_WIDTH'(1);
    vault_stock[1] = COUNT_WIDTH'(75);
    for (int i = 2; i < NUM_VALUES; i++) vault_stock[i] = COUNT_WIDTH'(100);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 21;
    recv_stall_pct = 50;
    test_withdraw_walk();
    test_deposit_edges();
    test_unused_kind();
    test_random_traffic(127);

    send_idle_pct = 50;
    recv_stall_pct = 21;
    test_random_traffic(127);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_traffic(126);

    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/nigd_pkg.sv
design/note_inventory_greedy_dispenser.sv
verif/note_inventory_greedy_dispenser_tb.sv
